[rtl/core/ph_trimmed_window_average_top_defines.svh]
// assertion macros for the ph trimmed window average block
// used by the modules that carry concurrent checks; no other dependencies
`ifndef PH_TRIMMED_WINDOW_AVERAGE_TOP_DEFINES_SVH
`define PH_TRIMMED_WINDOW_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define PTWA_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptwa: same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define PTWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptwa: next-cycle check failed");

`endif

[rtl/core/ptwa_pkg.sv]
// shared constants for the ph trimmed window average block
// no dependencies; used by ptwa_front, ptwa_back and the top level
`default_nettype none

package ptwa_pkg;

  // result and register field widths
  localparam int SUM_W = 16;
  localparam int PH_W  = 13;
  localparam int OFF_W = 10;

  // ph scale: 3.5 ph/V * 5.0 V * 100 over 1024 codes = 1750 / 2^10
  localparam int PH_SCALE_NUM = 1750;
  localparam int SCALE_NUM_W  = 11;
  localparam int SCALE_SHIFT  = 10;

  // depth of the sample queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[rtl/core/ptwa_front.sv]
// input side: accepts sample words and holds them in a short queue
// depends on ptwa_pkg for the queue depth
`default_nettype none

module ptwa_front #(
  parameter int ADC_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [ADC_BITS-1:0] in_adc_sample,
  output logic                     q_valid,
  output logic [ADC_BITS-1:0]      q_sample,
  input  wire logic                q_pop
);

  localparam int QD = ptwa_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  logic [ADC_BITS-1:0] slot_r [QD];
  logic [PW-1:0]       wr_ptr_r;
  logic [PW-1:0]       rd_ptr_r;
  logic [CW-1:0]       cnt_r;
  logic                push;

  // queue status toward both sides
  assign in_stall = (cnt_r == CW'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_sample = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // queue slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_adc_sample;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ptwa_back.sv]
// work side: ring memory, window walk for sum/min/max, scaling, result register
// depends on ptwa_pkg and the assertion macro header
`default_nettype none
`include "ph_trimmed_window_average_top_defines.svh"

module ptwa_back #(
  parameter int WINDOW   = 40,
  parameter int ADC_BITS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_valid,
  input  wire logic [ADC_BITS-1:0]               q_sample,
  output logic                                   q_pop,
  input  wire logic signed [ptwa_pkg::OFF_W-1:0] ph_offset,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [ptwa_pkg::SUM_W-1:0]             out_trimmed_sum,
  output logic signed [ptwa_pkg::PH_W-1:0]       out_ph_hundredths
);

  localparam int AW    = $clog2(WINDOW);
  localparam int TOT_W = ADC_BITS + $clog2(WINDOW);
  localparam int DIV   = WINDOW - 2;
  localparam int DL    = $clog2(DIV);
  localparam int XN    = TOT_W + 1;
  localparam int SH    = XN + DL;
  localparam int MW    = XN + 2;
  localparam int P1W   = TOT_W + ptwa_pkg::SCALE_NUM_W;
  localparam int P2W   = XN + MW;
  localparam int SUM_W = ptwa_pkg::SUM_W;
  localparam int PH_W  = ptwa_pkg::PH_W;
  localparam int OFF_W = ptwa_pkg::OFF_W;
  // reciprocal of the trim count, exact for every dividend below 2^XN
  localparam longint unsigned MAGIC = ((64'd1 << SH) + DIV - 1) / DIV;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_WALK,
    S_DRAIN,
    S_SUB,
    S_MULA,
    S_MULB,
    S_FINISH
  } state_t;

  state_t              state_r;
  logic [ADC_BITS-1:0] sample_r;
  logic [AW-1:0]       wp_r;
  logic [AW-1:0]       rd_addr_r;
  logic                rd_go_r;
  logic                rd_val_r;
  logic [WINDOW-1:0]   vbits_r;
  logic [ADC_BITS-1:0] rd_data_r;
  logic [ADC_BITS-1:0] ring_mem [WINDOW];
  logic [TOT_W-1:0]    tot_r;
  logic [ADC_BITS-1:0] lo_r;
  logic [ADC_BITS-1:0] hi_r;
  logic [TOT_W-1:0]    trim_r;
  logic [P1W-1:0]      p1_r;
  logic [P2W-1:0]      p2_r;
  logic                out_valid_r;
  logic [SUM_W-1:0]    out_sum_r;
  logic [PH_W-1:0]     out_ph_r;

  logic [ADC_BITS-1:0]    rd_word;
  logic [XN-1:0]          x_w;
  logic [P2W-1:0]         q_full;
  logic [PH_W-1:0]        ph_nxt;
  logic [SUM_W+TOT_W-1:0] sum_ext;
  logic                   out_free;

  // entries never written since reset read as zero
  assign rd_word  = rd_val_r ? rd_data_r : '0;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign out_free = !out_valid_r || !out_stall;

  // scaling: drop 10 fraction bits, then reciprocal multiply for the trim count
  assign x_w     = p1_r[P1W-1:ptwa_pkg::SCALE_SHIFT];
  assign q_full  = p2_r >> SH;
  assign ph_nxt  = q_full[PH_W-1:0] + {{(PH_W - OFF_W){ph_offset[OFF_W-1]}}, ph_offset};
  assign sum_ext = {{SUM_W{1'b0}}, trim_r};

  // sequencer, walk accumulators and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sample_r    <= '0;
      wp_r        <= '0;
      rd_addr_r   <= '0;
      rd_go_r     <= 1'b0;
      rd_val_r    <= 1'b0;
      vbits_r     <= '0;
      tot_r       <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      trim_r      <= '0;
      p1_r        <= '0;
      p2_r        <= '0;
      out_valid_r <= 1'b0;
      out_sum_r   <= '0;
      out_ph_r    <= '0;
    end else begin
      rd_go_r  <= (state_r == S_WALK);
      rd_val_r <= vbits_r[rd_addr_r];

      // fold in the word read in the previous cycle
      if (rd_go_r) begin
        tot_r <= tot_r + TOT_W'(rd_word);
        if (rd_word < lo_r) begin
          lo_r <= rd_word;
        end
        if (rd_word > hi_r) begin
          hi_r <= rd_word;
        end
      end

      // receiver takes the word; a finishing item reloads it instead
      if (out_valid_r && !out_stall && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            sample_r <= q_sample;
            state_r  <= S_WRITE;
          end
        end
        S_WRITE: begin
          vbits_r[wp_r] <= 1'b1;
          wp_r          <= (wp_r == AW'(WINDOW - 1)) ? '0 : wp_r + AW'(1);
          rd_addr_r     <= '0;
          tot_r         <= '0;
          lo_r          <= '1;
          hi_r          <= '0;
          state_r       <= S_WALK;
        end
        S_WALK: begin
          if (rd_addr_r == AW'(WINDOW - 1)) begin
            state_r <= S_DRAIN;
          end else begin
            rd_addr_r <= rd_addr_r + AW'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_SUB;
        end
        S_SUB: begin
          trim_r  <= tot_r - TOT_W'(lo_r) - TOT_W'(hi_r);
          state_r <= S_MULA;
        end
        S_MULA: begin
          p1_r    <= P1W'(trim_r) * P1W'(ptwa_pkg::PH_SCALE_NUM);
          state_r <= S_MULB;
        end
        S_MULB: begin
          p2_r    <= P2W'(x_w) * P2W'(MAGIC);
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_sum_r   <= sum_ext[SUM_W-1:0];
            out_ph_r    <= ph_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // sample ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      ring_mem[wp_r] <= sample_r;
    end
    rd_data_r <= ring_mem[rd_addr_r];
  end

  assign out_valid         = out_valid_r;
  assign out_trimmed_sum   = out_sum_r;
  assign out_ph_hundredths = signed'(out_ph_r);

  // checks
  `PTWA_ASSERT_NEXT(a_walk_starts_at_zero, clk, rst_n, state_r == S_WRITE, state_r == S_WALK && rd_addr_r == '0)
  `PTWA_ASSERT_HOLDS(a_walk_drained, clk, rst_n, state_r == S_SUB, !rd_go_r)
  `PTWA_ASSERT_HOLDS(a_min_not_above_max, clk, rst_n, state_r == S_SUB, lo_r <= hi_r)
  `PTWA_ASSERT_HOLDS(a_word_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r == S_FINISH))
  `PTWA_ASSERT_NEXT(a_finish_delivers, clk, rst_n, state_r == S_FINISH && out_free, out_valid_r && state_r == S_IDLE)

endmodule

`default_nettype wire

[rtl/core/ph_trimmed_window_average_top.sv]
// Trimmed moving average of pH probe converter words.
// Input channel: in_valid / in_stall / in_adc_sample, one sample per word.
// Output channel: out_valid / out_stall / out_trimmed_sum / out_ph_hundredths,
// exactly one word per accepted sample, in order.
// Config: cfg_wr_en / cfg_wr_data write the signed ph offset (hundredths).
// Each sample is written into a WINDOW-entry ring, the ring is walked once
// for sum, minimum and maximum, and the trimmed sum is scaled to ph.
// Each sample is carried to its result before the next one leaves the queue,
// as the walk goes through the single read port of the ring memory.
// A two-word queue keeps accepting while the ring walk runs, and the result
// register lets the next walk start while out_stall holds a finished word.
// Reset: synchronous, active low; the ring reads as all zeros, the write
// position and offset return to zero, both channels go empty.
// While out_stall is high the word holds; the walk then waits before loading
// a new word, and in_stall rises once the queue fills.
`default_nettype none

module ph_trimmed_window_average_top #(
  parameter int WINDOW   = 40,
  parameter int ADC_BITS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ADC_BITS-1:0]               in_adc_sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [ptwa_pkg::SUM_W-1:0]             out_trimmed_sum,
  output logic signed [ptwa_pkg::PH_W-1:0]       out_ph_hundredths,
  input  wire logic                              cfg_wr_en,
  input  wire logic signed [ptwa_pkg::OFF_W-1:0] cfg_wr_data
);

  logic                                 q_valid;
  logic [ADC_BITS-1:0]                  q_sample;
  logic                                 q_pop;
  logic signed [ptwa_pkg::OFF_W-1:0]    ph_offset_r;

  // calibration offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_offset_r <= '0;
    end else if (cfg_wr_en) begin
      ph_offset_r <= cfg_wr_data;
    end
  end

  // front: accept and queue sample words
  ptwa_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_adc_sample (in_adc_sample),
    .q_valid       (q_valid),
    .q_sample      (q_sample),
    .q_pop         (q_pop)
  );

  // back: ring update, window walk, scaling, result word
  ptwa_back #(
    .WINDOW   (WINDOW),
    .ADC_BITS (ADC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_sample          (q_sample),
    .q_pop             (q_pop),
    .ph_offset         (ph_offset_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trimmed_sum   (out_trimmed_sum),
    .out_ph_hundredths (out_ph_hundredths)
  );

endmodule

`default_nettype wire
